// File: rtl/sat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    localparam int SEQ_W = 32;
    localparam int TO_W  = 16;
    localparam int OP_W  = 3;
    localparam int EV_W  = 4;
    localparam int PC_W  = 5;

    localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [OP_W-1:0] OP_SEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_RECV  = 3'd1;
    localparam logic [OP_W-1:0] OP_ACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [EV_W-1:0] EV_NONE      = 4'd0;
    localparam logic [EV_W-1:0] EV_SENT      = 4'd1;
    localparam logic [EV_W-1:0] EV_ACCEPTED  = 4'd2;
    localparam logic [EV_W-1:0] EV_STALE     = 4'd3;
    localparam logic [EV_W-1:0] EV_SUCCESS   = 4'd4;
    localparam logic [EV_W-1:0] EV_FAILURE   = 4'd5;
    localparam logic [EV_W-1:0] EV_ACKLIST   = 4'd6;
    localparam logic [EV_W-1:0] EV_TABLEFULL = 4'd7;
    localparam logic [EV_W-1:0] EV_ACKFULL   = 4'd8;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic exec;
        logic pick;
        logic drain_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic start_scan;
        logic multi;
        logic is_tick;
        logic hit;
        logic out_free;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/seq_ack_timeout_tracker.sv
// Flow: ack and tick first scan every pending slot; each code then loads one result into the
// output register, except a drain with queued acks, which gives one result per ack, and a tick
// with expired entries, which gives one per failure. Output stalls hold each result until taken.
// One transaction at a time: a new one is taken only after its last result has been loaded.
// Reset: synchronous, active low; counters, valid bits and the queue count clear, timeout 100.
`timescale 1ns / 1ps
`default_nettype none

module seq_ack_timeout_tracker #(
    parameter int PENDING_DEPTH = 16,
    parameter int ACK_DEPTH     = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [sat_pkg::TO_W-1:0]  i_cfg_wdata,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [sat_pkg::OP_W-1:0]  i_operation,
    input  wire [sat_pkg::SEQ_W-1:0] i_seq_num,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [sat_pkg::EV_W-1:0] o_event_res,
    output logic [sat_pkg::SEQ_W-1:0] o_result_seq,
    output logic                     o_last,
    output logic                     o_acks_pending,
    output logic [sat_pkg::PC_W-1:0] o_pending_count
);
    import sat_pkg::*;

    // The walk counter indexes both the pending table and the ack queue.
    localparam int MAXD = (PENDING_DEPTH > ACK_DEPTH) ? PENDING_DEPTH : ACK_DEPTH;
    localparam int IW   = (MAXD > 1) ? $clog2(MAXD) : 1;

    t_cmd          cmd;
    t_status       st;
    logic [IW-1:0] idx;
    logic          in_acc;

    // A transaction is taken only while the controller is idle; a finished result can
    // still be waiting in the output register at that point.
    assign in_acc = i_valid && o_ready;

    sat_ctrl #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .IW           (IW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_acc  (in_acc),
        .i_st      (st),
        .o_in_ready(o_ready),
        .o_cmd     (cmd),
        .o_idx     (idx)
    );

    // The datapath holds the counters, the valid bits, the three memories and the
    // output register. Status fields shown on a result reflect the state after the
    // whole transaction, because every update finishes before the first result is loaded.
    sat_dp #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .ACK_DEPTH    (ACK_DEPTH),
        .IW           (IW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_operation),
        .i_seq_num      (i_seq_num),
        .i_out_ready    (i_ready),
        .i_cmd          (cmd),
        .i_idx          (idx),
        .o_st           (st),
        .o_out_valid    (o_valid),
        .o_event_res    (o_event_res),
        .o_result_seq   (o_result_seq),
        .o_last         (o_last),
        .o_acks_pending (o_acks_pending),
        .o_pending_count(o_pending_count)
    );

endmodule

`default_nettype wire

// File: rtl/sat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_ctrl #(
    parameter int PENDING_DEPTH = 16,
    parameter int IW            = 4
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_acc,
    input  sat_pkg::t_status i_st,
    output logic            o_in_ready,
    output sat_pkg::t_cmd   o_cmd,
    output logic [IW-1:0]   o_idx
);
    import sat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_SCAN_END = 7'b0000100,
        S_EXEC     = 7'b0001000,
        S_PICK     = 7'b0010000,
        S_DRN      = 7'b0100000,
        S_EMIT     = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_acc) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = i_st.start_scan ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_idx         = r_idx + IW'(1);
                if (r_idx == IW'(PENDING_DEPTH - 1)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_idx      = '0;
                if (i_st.multi) begin
                    n_state = i_st.is_tick ? S_PICK : S_DRN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_idx      = r_idx + IW'(1);
                if (i_st.hit) begin
                    n_state = S_EMIT;
                end
            end
            S_DRN: begin
                o_cmd.drain_rd = 1'b1;
                n_idx          = r_idx + IW'(1);
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = i_st.is_tick ? S_PICK : S_DRN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sat_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_dp #(
    parameter int PENDING_DEPTH = 16,
    parameter int ACK_DEPTH     = 16,
    parameter int IW            = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sat_pkg::TO_W-1:0]      i_cfg_wdata,
    input  wire [sat_pkg::OP_W-1:0]      i_operation,
    input  wire [sat_pkg::SEQ_W-1:0]     i_seq_num,
    input  wire                          i_out_ready,
    input  sat_pkg::t_cmd                i_cmd,
    input  wire [IW-1:0]                 i_idx,
    output sat_pkg::t_status             o_st,
    output logic                         o_out_valid,
    output logic [sat_pkg::EV_W-1:0]     o_event_res,
    output logic [sat_pkg::SEQ_W-1:0]    o_result_seq,
    output logic                         o_last,
    output logic                         o_acks_pending,
    output logic [sat_pkg::PC_W-1:0]     o_pending_count
);
    import sat_pkg::*;

    localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int AW  = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int ACW = $clog2(ACK_DEPTH + 1);

    logic [SEQ_W-1:0] m_seq  [PENDING_DEPTH];
    logic [SEQ_W-1:0] m_time [PENDING_DEPTH];
    logic [SEQ_W-1:0] m_ack  [ACK_DEPTH];

    logic [TO_W-1:0]          r_timeout;
    logic [SEQ_W-1:0]         r_send_seq, r_exp_seq, r_now;
    logic [PENDING_DEPTH-1:0] r_valid, r_mask;
    logic [PCW-1:0]           r_pcount;
    logic [ACW-1:0]           r_ack_cnt, r_drain_n;
    logic                     r_found, r_chk, r_out_valid;
    logic [OP_W-1:0]          r_op;
    logic [SEQ_W-1:0]         r_seq, r_rd_seq, r_rd_time, r_rd_ack;
    logic [PW-1:0]            r_slot;
    logic [EV_W-1:0]          r_res_code, r_out_code;
    logic [SEQ_W-1:0]         r_res_seq, r_out_seq;
    logic                     r_last, r_src_mem, r_out_last, r_out_ackp;
    logic [PCW-1:0]           r_out_pc;

    logic                     free_found;
    logic [PW-1:0]            free_slot;
    logic [PW-1:0]            pidx;
    logic [SEQ_W-1:0]         age;
    logic                     expired, match, recv_ok, ack_full, out_free;
    logic [PENDING_DEPTH-1:0] pick_bit;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = PENDING_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_found = 1'b1;
                free_slot  = PW'(k);
            end
        end
    end

    assign pidx     = i_idx[PW-1:0];
    assign pick_bit = PENDING_DEPTH'(1) << pidx;
    assign age      = r_now - r_rd_time;
    assign expired  = r_valid[r_slot] && (age >= {{(SEQ_W-TO_W){1'b0}}, r_timeout});
    assign match    = r_valid[r_slot] && (r_rd_seq == r_seq) && !r_found;
    assign ack_full = (r_ack_cnt >= ACW'(ACK_DEPTH));
    assign recv_ok  = (r_seq >= r_exp_seq) && !ack_full;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_st.start_scan = (i_operation == OP_ACK) || (i_operation == OP_TICK);
    assign o_st.multi      = ((r_op == OP_TICK) && (r_mask != '0))
                          || ((r_op == OP_DRAIN) && (r_drain_n != '0));
    assign o_st.is_tick    = (r_op == OP_TICK);
    assign o_st.hit        = r_mask[pidx];
    assign o_st.out_free   = out_free;
    assign o_st.last       = r_last;

    // Memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == OP_SEND) && free_found) begin
            m_seq[free_slot]  <= r_send_seq;
            m_time[free_slot] <= r_now;
        end
        if (i_cmd.exec && (r_op == OP_RECV) && recv_ok) begin
            m_ack[r_ack_cnt[AW-1:0]] <= r_seq;
        end
        if (i_cmd.scan_rd || (i_cmd.pick && r_mask[pidx])) begin
            r_rd_seq  <= m_seq[pidx];
            r_rd_time <= m_time[pidx];
        end
        if (i_cmd.drain_rd) begin
            r_rd_ack <= m_ack[i_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_send_seq  <= '0;
            r_exp_seq   <= '0;
            r_now       <= '0;
            r_valid     <= '0;
            r_mask      <= '0;
            r_pcount    <= '0;
            r_ack_cnt   <= '0;
            r_found     <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_chk <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_mask  <= '0;
                if (i_operation == OP_TICK) begin
                    r_now <= r_now + SEQ_W'(1);
                end
                if (i_operation == OP_DRAIN) begin
                    r_ack_cnt <= '0;
                end
                if (i_operation == OP_CLEAR) begin
                    r_valid   <= '0;
                    r_pcount  <= '0;
                    r_ack_cnt <= '0;
                end
            end
            if (r_chk) begin
                if ((r_op == OP_ACK) && match) begin
                    r_valid[r_slot] <= 1'b0;
                    r_pcount        <= r_pcount - PCW'(1);
                    r_found         <= 1'b1;
                end
                if ((r_op == OP_TICK) && expired) begin
                    r_valid[r_slot] <= 1'b0;
                    r_pcount        <= r_pcount - PCW'(1);
                    r_mask[r_slot]  <= 1'b1;
                end
            end
            if (i_cmd.exec) begin
                if ((r_op == OP_SEND) && free_found) begin
                    r_valid[free_slot] <= 1'b1;
                    r_pcount           <= r_pcount + PCW'(1);
                    r_send_seq         <= r_send_seq + SEQ_W'(1);
                end
                if ((r_op == OP_RECV) && recv_ok) begin
                    r_ack_cnt <= r_ack_cnt + ACW'(1);
                    r_exp_seq <= r_seq + SEQ_W'(1);
                end
            end
            if (i_cmd.pick && r_mask[pidx]) begin
                r_mask[pidx] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= pidx;
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_seq <= i_seq_num;
            if (i_operation == OP_DRAIN) begin
                r_drain_n <= r_ack_cnt;
            end
        end
        if (i_cmd.exec) begin
            r_last    <= 1'b1;
            r_src_mem <= 1'b0;
            case (r_op)
                OP_SEND: begin
                    r_res_code <= free_found ? EV_SENT : EV_TABLEFULL;
                    r_res_seq  <= r_send_seq;
                end
                OP_RECV: begin
                    if (r_seq < r_exp_seq) begin
                        r_res_code <= EV_STALE;
                    end else if (ack_full) begin
                        r_res_code <= EV_ACKFULL;
                    end else begin
                        r_res_code <= EV_ACCEPTED;
                    end
                    r_res_seq <= r_seq;
                end
                OP_ACK: begin
                    r_res_code <= r_found ? EV_SUCCESS : EV_NONE;
                    r_res_seq  <= r_seq;
                end
                OP_TICK: begin
                    r_res_code <= EV_NONE;
                    r_res_seq  <= r_now;
                end
                default: begin
                    r_res_code <= EV_NONE;
                    r_res_seq  <= '0;
                end
            endcase
        end
        if (i_cmd.pick && r_mask[pidx]) begin
            r_last    <= ((r_mask & ~pick_bit) == '0);
            r_src_mem <= 1'b1;
        end
        if (i_cmd.drain_rd) begin
            r_last    <= ((ACW'(i_idx) + ACW'(1)) == r_drain_n);
            r_src_mem <= 1'b1;
        end
        if (i_cmd.emit) begin
            if (r_src_mem) begin
                r_out_code <= (r_op == OP_TICK) ? EV_FAILURE : EV_ACKLIST;
                r_out_seq  <= (r_op == OP_TICK) ? r_rd_seq : r_rd_ack;
            end else begin
                r_out_code <= r_res_code;
                r_out_seq  <= r_res_seq;
            end
            r_out_last <= r_last;
            r_out_ackp <= (r_ack_cnt != '0);
            r_out_pc   <= r_pcount;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_out_code;
    assign o_result_seq    = r_out_seq;
    assign o_last          = r_out_last;
    assign o_acks_pending  = r_out_ackp;
    assign o_pending_count = PC_W'(r_out_pc);

    a_pcount_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_pcount))
        else $error("pending count does not match valid bits");
    a_ack_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ack_cnt <= ACW'(ACK_DEPTH))
        else $error("ack queue count beyond depth");
    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a waiting result");

endmodule

`default_nettype wire
